[src/rat_pkg.sv]
package rat_pkg;

    localparam int OP_W  = 3;
    localparam int POS_W = 8;
    localparam int VAL_W = 32;

    typedef enum logic [OP_W-1:0] {
        OP_SEARCH  = 3'd0,
        OP_MODIFY  = 3'd1,
        OP_APPEND  = 3'd2,
        OP_REPLACE = 3'd3,
        OP_REMOVE  = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_RANGE     = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        t_status                  status;
        logic [POS_W-1:0]         found;
        logic signed [VAL_W-1:0]  old;
    } t_res;

endpackage

[src/row_array_table_engine.sv]
// Table of signed 32-bit values held in up to ROWS rows of at most ROW_LEN
// entries; an entry's position is row*ROW_LEN+column.
// Input channel (i_in_valid / o_in_ready) carries one operation: search,
// modify, append, replace or remove. Output channel (o_out_valid /
// i_out_ready) returns exactly one result per operation: status, the found
// position of a search, and the old value of a modify.
// One operation is in work at a time; o_in_ready is high only while idle.
// Append writes its entry directly. Modify, replace and remove step row by
// row to locate the row, then check the column against its length; modify
// then writes the new value, remove shifts the rest of the row left. A search
// walks the rows in order, one cell per cycle within a row through the single
// read port of the cell memory, and stops at the first match.
// A finished result sits in the output register; the next operation is
// accepted while it waits, but its own result holds until that one is taken.
// Reset empties the table at once (row count and last row length zero); the
// cell memory and the row length memory need no clearing pass.
module row_array_table_engine #(
    parameter int ROW_LEN = 10,
    parameter int ROWS    = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [rat_pkg::OP_W-1:0]         i_operation,
    input  logic [rat_pkg::POS_W-1:0]        i_position,
    input  logic signed [rat_pkg::VAL_W-1:0] i_value,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [1:0]                       o_status,
    output logic [rat_pkg::POS_W-1:0]        o_found_position,
    output logic signed [rat_pkg::VAL_W-1:0] o_old_value
);
    import rat_pkg::*;

    logic r_out_valid;
    t_res r_out;
    logic res_valid;
    t_res res;
    logic res_take;

    assign res_take = res_valid && (!r_out_valid || i_out_ready);

    rat_ctrl #(.ROW_LEN(ROW_LEN), .ROWS(ROWS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_operation (i_operation),
        .i_position  (i_position),
        .i_value     (i_value),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (res_take)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (res_take) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out.status;
    assign o_found_position = r_out.found;
    assign o_old_value      = r_out.old;

endmodule

[src/rat_ram.sv]
module rat_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

[src/rat_ctrl.sv]
module rat_ctrl #(
    parameter int ROW_LEN = 10,
    parameter int ROWS    = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [rat_pkg::OP_W-1:0]      i_operation,
    input  logic [rat_pkg::POS_W-1:0]     i_position,
    input  logic signed [rat_pkg::VAL_W-1:0] i_value,
    output logic                          o_res_valid,
    output rat_pkg::t_res                 o_res,
    input  logic                          i_res_take
);
    import rat_pkg::*;

    localparam int DEPTH = ROWS * ROW_LEN;
    localparam int AW    = $clog2(DEPTH);
    localparam int BW    = $clog2(DEPTH + 1);
    localparam int RW    = $clog2(ROWS + 1);
    localparam int RIW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int LW    = $clog2(ROW_LEN + 1);
    localparam int PW    = (BW + 1 > POS_W) ? BW + 1 : POS_W + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_APPEND, S_LOC, S_LCHK, S_MODW, S_SHIFT, S_SLEN, S_SCAP, S_SCAN, S_DONE
    } t_state;

    t_state            r_state;
    t_op               r_op;
    logic [POS_W-1:0]  r_pos;
    logic [VAL_W-1:0]  r_value;
    logic [RW-1:0]     r_count;
    logic [RW-1:0]     r_row;
    logic [BW-1:0]     r_base;
    logic [BW-1:0]     r_next_base;
    logic [LW-1:0]     r_last_len;
    logic [LW-1:0]     r_col;
    logic [LW-1:0]     r_len;
    logic              r_pend;
    logic [AW-1:0]     r_pend_addr;
    t_res              r_res;

    logic              cell_we;
    logic [AW-1:0]     cell_waddr;
    logic [VAL_W-1:0]  cell_wdata;
    logic [AW-1:0]     cell_raddr;
    logic [VAL_W-1:0]  cell_rdata;
    logic              len_we;
    logic [RIW-1:0]    len_waddr;
    logic [LW-1:0]     len_wdata;
    logic [LW-1:0]     len_rdata;

    logic [BW-1:0]     cur_sum;
    logic [BW-1:0]     nxt_sum;
    logic [BW-1:0]     tail_sum;
    logic [AW-1:0]     cur_addr;
    logic [RW-1:0]     cnt_m1;
    logic [PW-1:0]     pos_ext;
    logic [PW-1:0]     base_ext;
    logic              open_row;
    logic              more_shift;

    assign cur_sum    = r_base + BW'(r_col);
    assign nxt_sum    = cur_sum + BW'(1);
    assign tail_sum   = r_next_base - BW'(ROW_LEN) + BW'(r_last_len);
    assign cur_addr   = cur_sum[AW-1:0];
    assign cnt_m1     = r_count - RW'(1);
    assign pos_ext    = PW'(r_pos);
    assign base_ext   = PW'(r_base);
    assign open_row   = (r_count == '0) || (r_last_len >= LW'(ROW_LEN));
    assign more_shift = ({1'b0, r_col} + (LW + 1)'(1)) < {1'b0, r_len};

    rat_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_cells (
        .i_clk   (i_clk),
        .i_we    (cell_we),
        .i_waddr (cell_waddr),
        .i_wdata (cell_wdata),
        .i_raddr (cell_raddr),
        .o_rdata (cell_rdata)
    );

    // entries at or above the row count are never read, so no clear is needed
    rat_ram #(.WIDTH(LW), .DEPTH(ROWS)) u_lens (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (len_waddr),
        .i_wdata (len_wdata),
        .i_raddr (r_row[RIW-1:0]),
        .o_rdata (len_rdata)
    );

    always_comb begin
        cell_we    = 1'b0;
        cell_waddr = cur_addr;
        cell_wdata = r_value;
        cell_raddr = cur_addr;
        len_we     = 1'b0;
        len_waddr  = r_row[RIW-1:0];
        len_wdata  = r_len - LW'(1);
        case (r_state)
            S_APPEND: begin
                if (open_row) begin
                    cell_we    = (r_count < RW'(ROWS));
                    cell_waddr = r_next_base[AW-1:0];
                    len_we     = (r_count < RW'(ROWS));
                    len_waddr  = r_count[RIW-1:0];
                    len_wdata  = LW'(1);
                end else begin
                    cell_we    = 1'b1;
                    cell_waddr = tail_sum[AW-1:0];
                    len_we     = 1'b1;
                    len_waddr  = cnt_m1[RIW-1:0];
                    len_wdata  = r_last_len + LW'(1);
                end
            end
            S_LCHK: begin
                cell_we = (r_col < len_rdata) && (r_op == OP_REPLACE);
            end
            S_MODW: begin
                cell_we = 1'b1;
            end
            S_SHIFT: begin
                // drop the element read last cycle one place left
                cell_we    = r_pend;
                cell_waddr = r_pend_addr;
                cell_wdata = cell_rdata;
                cell_raddr = nxt_sum[AW-1:0];
                len_we     = !more_shift;
            end
            default: begin
            end
        endcase
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_next_base <= '0;
            r_last_len  <= '0;
            r_pend      <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op         <= t_op'(i_operation);
                        r_pos        <= i_position;
                        r_value      <= i_value;
                        r_row        <= '0;
                        r_base       <= '0;
                        r_pend       <= 1'b0;
                        r_res.status <= ST_OK;
                        r_res.found  <= '0;
                        r_res.old    <= '0;
                        case (t_op'(i_operation))
                            OP_SEARCH:  r_state <= S_SLEN;
                            OP_MODIFY:  r_state <= S_LOC;
                            OP_REPLACE: r_state <= S_LOC;
                            OP_REMOVE:  r_state <= S_LOC;
                            OP_APPEND:  r_state <= S_APPEND;
                            default:    r_state <= S_DONE;
                        endcase
                    end
                end
                S_APPEND: begin
                    if (open_row) begin
                        if (r_count < RW'(ROWS)) begin
                            r_count     <= r_count + RW'(1);
                            r_next_base <= r_next_base + BW'(ROW_LEN);
                            r_last_len  <= LW'(1);
                        end else begin
                            r_res.status <= ST_FULL;
                        end
                    end else begin
                        r_last_len <= r_last_len + LW'(1);
                    end
                    r_state <= S_DONE;
                end
                S_LOC: begin
                    if (r_row >= r_count) begin
                        r_res.status <= ST_RANGE;
                        r_state      <= S_DONE;
                    end else if (pos_ext < base_ext + PW'(ROW_LEN)) begin
                        r_col   <= LW'(pos_ext - base_ext);
                        r_state <= S_LCHK;
                    end else begin
                        r_row  <= r_row + RW'(1);
                        r_base <= r_base + BW'(ROW_LEN);
                    end
                end
                S_LCHK: begin
                    r_len <= len_rdata;
                    if (r_col >= len_rdata) begin
                        r_res.status <= ST_RANGE;
                        r_state      <= S_DONE;
                    end else begin
                        case (r_op)
                            OP_MODIFY: r_state <= S_MODW;
                            OP_REMOVE: r_state <= S_SHIFT;
                            default:   r_state <= S_DONE;
                        endcase
                    end
                end
                S_MODW: begin
                    r_res.old <= cell_rdata;
                    r_state   <= S_DONE;
                end
                S_SHIFT: begin
                    if (more_shift) begin
                        r_pend      <= 1'b1;
                        r_pend_addr <= cur_addr;
                        r_col       <= r_col + LW'(1);
                    end else begin
                        r_pend <= 1'b0;
                        if (r_row == cnt_m1) begin
                            r_last_len <= r_len - LW'(1);
                        end
                        r_state <= S_DONE;
                    end
                end
                S_SLEN: begin
                    if (r_row < r_count) begin
                        r_state <= S_SCAP;
                    end else begin
                        r_res.status <= ST_NOT_FOUND;
                        r_state      <= S_DONE;
                    end
                end
                S_SCAP: begin
                    r_len   <= len_rdata;
                    r_col   <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    // compare the cell read last cycle while the next one is fetched
                    if (r_pend && (cell_rdata == r_value)) begin
                        r_pend       <= 1'b0;
                        r_res.found  <= POS_W'(r_pend_addr);
                        r_state      <= S_DONE;
                    end else if (r_col < r_len) begin
                        r_pend      <= 1'b1;
                        r_pend_addr <= cur_addr;
                        r_col       <= r_col + LW'(1);
                    end else begin
                        r_pend  <= 1'b0;
                        r_row   <= r_row + RW'(1);
                        r_base  <= r_base + BW'(ROW_LEN);
                        r_state <= S_SLEN;
                    end
                end
                S_DONE: begin
                    if (i_res_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[verif/tb_row_array_table_engine.sv]
`timescale 1ns / 1ps

// Scoreboard: keeps its own copy of the table, predicts each result on transfer
// and compares the results in order.
class table_scoreboard;
    localparam int ROW_LEN = 10;
    localparam int ROWS    = 16;

    rat_pkg::t_res                        expected_results[$];
    logic signed [rat_pkg::VAL_W-1:0]     cells[ROWS*ROW_LEN];
    int unsigned                          row_len[ROWS];
    int unsigned                          row_count;
    int                                   error_count;
    int                                   checked_count;

    function new();
        foreach (cells[i]) cells[i] = '0;
        foreach (row_len[i]) row_len[i] = 0;
        row_count     = 0;
        error_count   = 0;
        checked_count = 0;
    endfunction

    function bit locate(logic [rat_pkg::POS_W-1:0] pos, output int unsigned r,
                        output int unsigned c);
        r = pos / ROW_LEN;
        c = pos % ROW_LEN;
        return (r < row_count) && (r < ROWS) && (c < row_len[r]);
    endfunction

    function void note_operation(logic [rat_pkg::OP_W-1:0] op,
                                 logic [rat_pkg::POS_W-1:0] pos,
                                 logic signed [rat_pkg::VAL_W-1:0] val);
        rat_pkg::t_res res;
        int unsigned   r;
        int unsigned   c;
        int unsigned   i;
        int unsigned   j;
        res        = '0;
        res.status = rat_pkg::ST_OK;
        case (op)
            rat_pkg::OP_SEARCH: begin
                res.status = rat_pkg::ST_NOT_FOUND;
                for (i = 0; i < row_count && res.status != rat_pkg::ST_OK; i++) begin
                    for (j = 0; j < row_len[i] && res.status != rat_pkg::ST_OK; j++) begin
                        if (cells[i*ROW_LEN+j] == val) begin
                            res.status = rat_pkg::ST_OK;
                            res.found  = i*ROW_LEN + j;
                        end
                    end
                end
            end
            rat_pkg::OP_MODIFY: begin
                if (locate(pos, r, c)) begin
                    res.old             = cells[r*ROW_LEN+c];
                    cells[r*ROW_LEN+c]  = val;
                end else begin
                    res.status = rat_pkg::ST_RANGE;
                end
            end
            rat_pkg::OP_APPEND: begin
                if (row_count == 0 || row_len[row_count-1] >= ROW_LEN) begin
                    // open a new row unless every row is taken
                    if (row_count >= ROWS) begin
                        res.status = rat_pkg::ST_FULL;
                    end else begin
                        row_len[row_count]         = 1;
                        cells[row_count*ROW_LEN]   = val;
                        row_count++;
                    end
                end else begin
                    r = row_count - 1;
                    cells[r*ROW_LEN+row_len[r]] = val;
                    row_len[r]++;
                end
            end
            rat_pkg::OP_REPLACE: begin
                if (locate(pos, r, c)) cells[r*ROW_LEN+c] = val;
                else res.status = rat_pkg::ST_RANGE;
            end
            rat_pkg::OP_REMOVE: begin
                if (locate(pos, r, c)) begin
                    for (j = c; j + 1 < row_len[r]; j++)
                        cells[r*ROW_LEN+j] = cells[r*ROW_LEN+j+1];
                    row_len[r]--;
                end else begin
                    res.status = rat_pkg::ST_RANGE;
                end
            end
            default: ;
        endcase
        expected_results = {expected_results, res};
    endfunction

    function void check_result(logic [1:0] status, logic [rat_pkg::POS_W-1:0] found,
                               logic signed [rat_pkg::VAL_W-1:0] old);
        rat_pkg::t_res exp_res;
        checked_count++;
        if (expected_results.size() == 0) begin
            error_count++;
            if (error_count <= 10)
                $display("%0t: result with nothing pending: status %0d found %0d old %0d",
                         $time, status, found, old);
            return;
        end
        exp_res = expected_results.pop_front();
        if (status !== exp_res.status || found !== exp_res.found || old !== exp_res.old) begin
            error_count++;
            if (error_count <= 10)
                $display("%0t: mismatch exp/got: status %0d/%0d found %0d/%0d old %0d/%0d",
                         $time, exp_res.status, status, exp_res.found, found,
                         exp_res.old, old);
        end
    endfunction
endclass

module tb_row_array_table_engine;
    import rat_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;
    localparam int              HOLD_CYCLES    = 400;
    localparam int              DRAIN_CYCLES   = 300;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic [OP_W-1:0]         i_operation;
    logic [POS_W-1:0]        i_position;
    logic signed [VAL_W-1:0] i_value;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic [1:0]              o_status;
    logic [POS_W-1:0]        o_found_position;
    logic signed [VAL_W-1:0] o_old_value;

    bit                      idle_enable;
    table_scoreboard         table_sb = new();

    row_array_table_engine u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_operation      (i_operation),
        .i_position       (i_position),
        .i_value          (i_value),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_found_position (o_found_position),
        .o_old_value      (o_old_value)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Present one operation and hold it until the transfer.
    task automatic send_op(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                           logic signed [VAL_W-1:0] val);
        @(negedge i_clk);
        while (idle_enable && $urandom_range(99) < 28) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_operation = op;
        i_position  = pos;
        i_value     = val;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        table_sb.note_operation(op, pos, val);
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    2: return 32'sh0;
                    default: return -32'sd1;
                endcase
            end
            1, 2, 3, 4: return int'($urandom_range(6)) - 3;
            default: return $urandom;
        endcase
    endfunction

    // Position of an entry that is currently stored, when one is easy to find.
    function automatic logic [POS_W-1:0] stored_position();
        int unsigned r;
        int          t;
        for (t = 0; t < 8 && table_sb.row_count != 0; t++) begin
            r = $urandom_range(table_sb.row_count - 1);
            if (table_sb.row_len[r] != 0)
                return POS_W'(r*10 + $urandom_range(table_sb.row_len[r] - 1));
        end
        return POS_W'($urandom_range(159));
    endfunction

    function automatic logic [POS_W-1:0] target_position();
        int unsigned r;
        case ($urandom_range(19))
            0: return POS_W'($urandom_range(255));
            1, 2: begin
                // at or past the end of a row, inside its columns (last column if full)
                if (table_sb.row_count == 0) return POS_W'($urandom_range(159));
                r = $urandom_range(table_sb.row_count - 1);
                return POS_W'(r*10 + $urandom_range(9, table_sb.row_len[r] < 10 ?
                                                    table_sb.row_len[r] : 9));
            end
            default: return stored_position();
        endcase
    endfunction

    task automatic random_op(int phase);
        int                      w_search;
        int                      w_modify;
        int                      w_append;
        int                      w_replace;
        int                      w_remove;
        int                      roll;
        logic [OP_W-1:0]         op;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] val;
        case (phase)
            0: begin w_search = 20; w_modify = 10; w_append = 45; w_replace = 10; w_remove = 8; end
            1: begin w_search = 8;  w_modify = 4;  w_append = 80; w_replace = 3;  w_remove = 2; end
            2: begin w_search = 35; w_modify = 15; w_append = 12; w_replace = 15; w_remove = 15; end
            default: begin
                w_search = 20; w_modify = 8; w_append = 5; w_replace = 7; w_remove = 55;
            end
        endcase
        roll = $urandom_range(99);
        pos  = target_position();
        val  = pick_value();
        if (roll < w_search) begin
            op = OP_SEARCH;
            pos = POS_W'($urandom_range(255));
            if (table_sb.row_count != 0 && $urandom_range(9) < 6)
                val = table_sb.cells[stored_position()];
        end else if (roll < w_search + w_modify) begin
            op = OP_MODIFY;
        end else if (roll < w_search + w_modify + w_append) begin
            op = OP_APPEND;
        end else if (roll < w_search + w_modify + w_append + w_replace) begin
            op = OP_REPLACE;
        end else if (roll < w_search + w_modify + w_append + w_replace + w_remove) begin
            op = OP_REMOVE;
        end else begin
            // noise: spare codes or any position at all
            op  = $urandom_range(1) ? OP_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST))
                                    : OP_W'($urandom_range(OP_REMOVE));
            pos = POS_W'($urandom_range(255));
            val = $urandom;
        end
        send_op(op, pos, val);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            table_sb.check_result(o_status, o_found_position, o_old_value);
    end

    // Result side: random stalls, plus one long hold-off that backs up the input.
    initial begin
        bit held;
        held        = 1'b0;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held && table_sb.checked_count >= 120) begin
                held        = 1'b1;
                i_out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                i_out_ready = !(idle_enable && $urandom_range(99) < 28);
            end
        end
    end

    initial begin
        logic [OP_W-1:0] spare;
        int              k;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_operation = '0;
        i_position  = '0;
        i_value     = '0;
        idle_enable = 1'b1;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty table: miss and out-of-range accesses
        send_op(OP_SEARCH,  8'd0,   32'sd5);
        send_op(OP_MODIFY,  8'd0,   32'sd1);
        send_op(OP_REMOVE,  8'd0,   32'sd1);
        // append to the empty table opens row 0
        send_op(OP_APPEND,  8'd0,   32'sh8000_0000);
        send_op(OP_APPEND,  8'd255, 32'sh7fff_ffff);
        send_op(OP_APPEND,  8'd0,   32'sh0);
        send_op(OP_APPEND,  8'd0,   -32'sd1);
        send_op(OP_SEARCH,  8'd0,   -32'sd1);
        send_op(OP_SEARCH,  8'd0,   32'sh7fff_ffff);
        send_op(OP_MODIFY,  8'd1,   32'sd12345);
        send_op(OP_REPLACE, 8'd2,   -32'sd1);
        // two equal values: the first one wins
        send_op(OP_SEARCH,  8'd0,   -32'sd1);
        send_op(OP_REMOVE,  8'd0,   32'sd0);
        send_op(OP_SEARCH,  8'd0,   32'sh8000_0000);
        send_op(OP_MODIFY,  8'd255, 32'sd7);
        send_op(OP_REPLACE, 8'd3,   32'sd7);
        send_op(OP_REMOVE,  8'd10,  32'sd0);
        for (spare = OP_SPARE_FIRST; spare != 3'd0; spare++)
            send_op(spare, 8'd255, -32'sd1);
        send_op(OP_REMOVE,  8'd2,   32'sd0);
        send_op(OP_SEARCH,  8'd1,   32'sd12345);

        for (k = 0; k < 200; k++) random_op(0);
        idle_enable = 1'b0;
        for (k = 0; k < 150; k++) random_op(1);
        idle_enable = 1'b1;
        for (k = 0; k < 150; k++) random_op(2);
        for (k = 0; k < 130; k++) random_op(3);

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (table_sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (table_sb.error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
